FILE: rtl/id3tfe_pkg.sv
// ----------------------------------------------------------------------------
// ID3 text frame extractor package
// Beat types, result codes, parser phases and the frame id lookup.
// ----------------------------------------------------------------------------
package id3tfe_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] field_code;
        logic [7:0] text_char;
        logic       last_of_field;
        logic       tag_done;
    } out_beat_t;

    localparam logic [2:0] ST_TEXT_CHAR   = 3'd0;
    localparam logic [2:0] ST_EMPTY_FIELD = 3'd1;
    localparam logic [2:0] ST_TAG_DONE    = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd3;
    localparam logic [2:0] ST_BAD_VERSION = 3'd4;

    localparam logic [2:0] MAX_FIELDS = 3'd6;

    localparam logic [7:0] MAGIC_0      = 8'h49;
    localparam logic [7:0] MAGIC_1      = 8'h44;
    localparam logic [7:0] MAGIC_2      = 8'h33;
    localparam logic [7:0] MAJOR_VER    = 8'h03;
    localparam logic [7:0] ENC_LATIN    = 8'h00;
    localparam logic [7:0] ENC_UTF16    = 8'h01;
    localparam logic [7:0] ENC_UTF16_BE = 8'h02;

    localparam logic [3:0] STEP_MAGIC_LAST = 4'd2;
    localparam logic [3:0] STEP_VERSION    = 4'd3;
    localparam logic [3:0] STEP_SIZE_FIRST = 4'd6;
    localparam logic [3:0] STEP_ID_END     = 4'd4;
    localparam logic [3:0] STEP_SIZE_END   = 4'd8;
    localparam logic [3:0] STEP_HDR_LAST   = 4'd9;
    localparam logic [3:0] BOM_BYTES       = 4'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FRAME_HDR,
        PH_ENCODING,
        PH_BOM,
        PH_TEXT,
        PH_SKIP,
        PH_STOPPED
    } phase_t;

    localparam int unsigned NUM_IDS = 6;
    localparam logic [31:0] FRAME_IDS [NUM_IDS] = '{
        32'h54504531, 32'h54495432, 32'h54414C42,
        32'h54594552, 32'h54434F4E, 32'h54434F4D
    };

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } id_match_t;

    function automatic id_match_t lookup_id(input logic [31:0] id);
        id_match_t m;
        m = '0;
        for (int i = NUM_IDS - 1; i >= 0; i--) begin
            if (FRAME_IDS[i] == id) begin
                m.hit  = 1'b1;
                m.code = 3'(i);
            end
        end
        return m;
    endfunction

endpackage

FILE: rtl/id3tfe_in_stage.sv
// ----------------------------------------------------------------------------
// ID3 text frame extractor input stage
// Holds one input beat until the parser consumes it.
// ----------------------------------------------------------------------------
module id3tfe_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  id3tfe_pkg::in_beat_t s_data,
    input  logic                fire,
    output logic                in_valid,
    output id3tfe_pkg::in_beat_t in_data
);
    import id3tfe_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t data_reg;
    logic     accept;

    assign s_ready = !valid_reg || fire;
    assign accept  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= s_data;
        end
    end

    assign in_valid = valid_reg;
    assign in_data  = data_reg;

endmodule

FILE: rtl/id3tfe_parser.sv
// ----------------------------------------------------------------------------
// ID3 text frame extractor parser
// Tag header check and frame walk; one byte per fire, at most one result.
// ----------------------------------------------------------------------------
module id3tfe_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  id3tfe_pkg::in_beat_t  in_data,
    output logic                 res_valid,
    output id3tfe_pkg::out_beat_t res
);
    import id3tfe_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  step_reg, step_next;
    logic [27:0] tag_reg, tag_next;
    logic [31:0] fb_reg, fb_next;
    logic [31:0] id_reg, id_next;
    logic [2:0]  field_reg, field_next;
    logic [1:0]  enc_reg, enc_next;
    logic        pair_reg, pair_next;
    logic [2:0]  ff_reg, ff_next;
    logic        seen_reg, seen_next;

    logic        sof;
    logic [7:0]  b;
    phase_t      eff_phase;
    logic [3:0]  eff_step;
    logic [27:0] eff_tag;
    logic [2:0]  eff_ff;
    logic [27:0] hdr_tag;
    logic [27:0] tag_dec;
    logic [31:0] fb_dec;
    logic [31:0] fb_clamp;
    logic        fb_end;
    logic        enc_ok;
    id_match_t   match;
    logic        stop;

    assign sof       = in_data.start_of_file;
    assign b         = in_data.data_byte;
    assign eff_phase = sof ? PH_HEADER : phase_reg;
    assign eff_step  = sof ? 4'd0 : step_reg;
    assign eff_tag   = sof ? 28'd0 : tag_reg;
    assign eff_ff    = sof ? 3'd0 : ff_reg;
    assign hdr_tag   = {eff_tag[20:0], b[6:0]};
    assign tag_dec   = eff_tag - 28'd1;
    assign fb_dec    = (fb_reg != 32'd0) ? fb_reg - 32'd1 : fb_reg;
    assign fb_end    = (fb_dec == 32'd0);
    assign fb_clamp  = (fb_reg > {4'd0, tag_dec}) ? {4'd0, tag_dec} : fb_reg;
    assign enc_ok    = (b <= ENC_UTF16_BE);
    assign match     = lookup_id(id_reg);

    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        stop      = 1'b0;
        unique case (eff_phase)
            PH_HEADER: begin
                if (eff_step <= STEP_MAGIC_LAST) begin
                    if ((eff_step == 4'd0 && b != MAGIC_0) ||
                        (eff_step == 4'd1 && b != MAGIC_1) ||
                        (eff_step == STEP_MAGIC_LAST && b != MAGIC_2)) begin
                        res_valid = 1'b1;
                        res.status = ST_BAD_MAGIC;
                        stop = 1'b1;
                    end
                end else if (eff_step == STEP_VERSION) begin
                    if (b != MAJOR_VER) begin
                        res_valid = 1'b1;
                        res.status = ST_BAD_VERSION;
                        stop = 1'b1;
                    end
                end else if (eff_step >= STEP_HDR_LAST && hdr_tag == 28'd0) begin
                    res_valid = 1'b1;
                    res.status = ST_TAG_DONE;
                    stop = 1'b1;
                end
            end
            PH_FRAME_HDR, PH_ENCODING, PH_BOM, PH_TEXT, PH_SKIP: begin
                if (eff_tag == 28'd0) begin
                    res_valid = 1'b1;
                    res.status = ST_TAG_DONE;
                    stop = 1'b1;
                end else begin
                    case (eff_phase)
                        PH_FRAME_HDR: begin
                            if (eff_step == 4'd0 && b == 8'd0) begin
                                res_valid = 1'b1;
                                res.status = ST_TAG_DONE;
                                stop = 1'b1;
                            end
                        end
                        PH_ENCODING: begin
                            if (match.hit && enc_ok && fb_end) begin
                                res_valid = 1'b1;
                                res.status = ST_EMPTY_FIELD;
                                res.field_code = match.code;
                                res.last_of_field = 1'b1;
                                stop = (eff_ff + 3'd1 >= MAX_FIELDS);
                            end
                        end
                        PH_BOM: begin
                            if (fb_end) begin
                                res_valid = 1'b1;
                                res.status = ST_EMPTY_FIELD;
                                res.field_code = field_reg;
                                res.last_of_field = 1'b1;
                                stop = (eff_ff >= MAX_FIELDS);
                            end
                        end
                        PH_TEXT: begin
                            if (enc_reg == ENC_LATIN[1:0]) begin
                                res_valid = 1'b1;
                                res.status = ST_TEXT_CHAR;
                                res.field_code = field_reg;
                                res.text_char = b;
                                res.last_of_field = fb_end;
                            end else if (!pair_reg && fb_reg >= 32'd2) begin
                                res_valid = 1'b1;
                                res.status = ST_TEXT_CHAR;
                                res.field_code = field_reg;
                                res.text_char = b;
                                res.last_of_field = (fb_dec < 32'd3);
                            end else if (fb_end && !seen_reg) begin
                                res_valid = 1'b1;
                                res.status = ST_EMPTY_FIELD;
                                res.field_code = field_reg;
                                res.last_of_field = 1'b1;
                            end
                            stop = res.last_of_field && (eff_ff >= MAX_FIELDS);
                        end
                        default: begin
                        end
                    endcase
                    res.tag_done = stop;
                    if (!stop && tag_dec == 28'd0) begin
                        if (!res_valid) begin
                            res_valid = 1'b1;
                            res.status = ST_TAG_DONE;
                        end
                        stop = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.tag_done = stop && res_valid;
    end

    always_comb begin
        phase_next = eff_phase;
        step_next  = eff_step;
        tag_next   = eff_tag;
        fb_next    = fb_reg;
        id_next    = id_reg;
        field_next = field_reg;
        enc_next   = enc_reg;
        pair_next  = pair_reg;
        ff_next    = eff_ff;
        seen_next  = seen_reg;
        unique case (eff_phase)
            PH_HEADER: begin
                if (eff_step >= STEP_SIZE_FIRST) begin
                    tag_next = hdr_tag;
                end
                if (eff_step >= STEP_HDR_LAST) begin
                    step_next  = 4'd0;
                    phase_next = PH_FRAME_HDR;
                end else begin
                    step_next = eff_step + 4'd1;
                end
            end
            PH_FRAME_HDR, PH_ENCODING, PH_BOM, PH_TEXT, PH_SKIP: begin
                if (eff_tag != 28'd0) begin
                    tag_next = tag_dec;
                    case (eff_phase)
                        PH_FRAME_HDR: begin
                            if (eff_step < STEP_ID_END) begin
                                id_next = {id_reg[23:0], b};
                            end else if (eff_step < STEP_SIZE_END) begin
                                fb_next = {fb_reg[23:0], b};
                            end
                            if (eff_step >= STEP_HDR_LAST) begin
                                step_next = 4'd0;
                                fb_next   = fb_clamp;
                                if (fb_clamp != 32'd0) begin
                                    phase_next = PH_ENCODING;
                                end
                            end else begin
                                step_next = eff_step + 4'd1;
                            end
                        end
                        PH_ENCODING: begin
                            fb_next = fb_dec;
                            if (match.hit && enc_ok) begin
                                field_next = match.code;
                                enc_next   = b[1:0];
                                pair_next  = 1'b0;
                                seen_next  = 1'b0;
                                step_next  = 4'd0;
                                ff_next    = eff_ff + 3'd1;
                                phase_next = (b == ENC_UTF16) ? PH_BOM : PH_TEXT;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_BOM: begin
                            fb_next = fb_dec;
                            if (eff_step + 4'd1 >= BOM_BYTES) begin
                                step_next  = 4'd0;
                                phase_next = PH_TEXT;
                            end else begin
                                step_next = eff_step + 4'd1;
                            end
                        end
                        PH_TEXT: begin
                            fb_next = fb_dec;
                            if (enc_reg == ENC_LATIN[1:0]) begin
                                seen_next = 1'b1;
                            end else if (!pair_reg) begin
                                if (fb_reg >= 32'd2) begin
                                    seen_next = 1'b1;
                                    pair_next = 1'b1;
                                end
                            end else begin
                                pair_next = 1'b0;
                            end
                        end
                        default: begin
                            fb_next = fb_dec;
                        end
                    endcase
                    if (eff_phase != PH_FRAME_HDR && fb_end) begin
                        phase_next = PH_FRAME_HDR;
                        step_next  = 4'd0;
                    end
                end
            end
            default: begin
            end
        endcase
        if (stop) begin
            phase_next = PH_STOPPED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            step_reg  <= '0;
            tag_reg   <= '0;
            fb_reg    <= '0;
            id_reg    <= '0;
            field_reg <= '0;
            enc_reg   <= '0;
            pair_reg  <= 1'b0;
            ff_reg    <= '0;
            seen_reg  <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            tag_reg   <= tag_next;
            fb_reg    <= fb_next;
            id_reg    <= id_next;
            field_reg <= field_next;
            enc_reg   <= enc_next;
            pair_reg  <= pair_next;
            ff_reg    <= ff_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

FILE: rtl/id3tfe_out_stage.sv
// ----------------------------------------------------------------------------
// ID3 text frame extractor output stage
// Result register that holds a beat until the consumer takes it.
// ----------------------------------------------------------------------------
module id3tfe_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  id3tfe_pkg::out_beat_t res,
    output logic                 m_valid,
    input  logic                 m_ready,
    output id3tfe_pkg::out_beat_t m_data
);
    import id3tfe_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_beat_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

FILE: rtl/id3_text_frame_extractor_top.sv
// A byte waits in the input register until the parser takes it; its result is
// then loaded into the result register. Throughput: one byte per cycle unless
// the result register is held, set by the single parser pass between the two.
// Reset: synchronous active-low aresetn clears both stages and the parser;
// a beat with start_of_file restarts parsing at that byte.
// ----------------------------------------------------------------------------
// ID3 text frame extractor
// Parses an ID3v2.3 tag from a byte stream and emits the text of six frames.
// ----------------------------------------------------------------------------
module id3_text_frame_extractor_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  id3tfe_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output id3tfe_pkg::out_beat_t m_data
);
    import id3tfe_pkg::*;

    logic      in_valid;
    in_beat_t  in_data;
    logic      fire;
    logic      res_valid;
    out_beat_t res;
    logic      load;

    assign fire = in_valid && (!m_valid || m_ready);
    assign load = fire && res_valid;

    id3tfe_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .fire     (fire),
        .in_valid (in_valid),
        .in_data  (in_data)
    );

    id3tfe_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res       (res)
    );

    id3tfe_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && !fire |-> !s_ready)
        else $error("Input stage accepted a beat while occupied.");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("Loaded result is not presented.");

    a_stop_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_TAG_DONE || m_data.status == ST_BAD_MAGIC ||
        m_data.status == ST_BAD_VERSION) |-> m_data.tag_done)
        else $error("Terminal status without tag_done.");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && fire |-> res.field_code < MAX_FIELDS)
        else $error("Field code out of range.");
`endif

endmodule

FILE: tb/sv/id3tfe_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ID3 text frame extractor scoreboard
// Tracks the tag parser state for every accepted byte, predicts the result
// beat that the byte causes, and compares each result beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
package id3tfe_tb_pkg;
    import id3tfe_pkg::*;

    localparam logic [31:0] TEXT_FRAME_IDS [6] = '{
        "TPE1", "TIT2", "TALB", "TYER", "TCON", "TCOM"
    };
    localparam int unsigned FIELD_LIMIT = 6;

    class id3_text_scoreboard;
        phase_t      phase;
        logic [3:0]  step;
        logic [27:0] tag_left;
        logic [31:0] frame_left;
        logic [31:0] frame_id;
        logic [2:0]  field;
        logic [1:0]  enc_mode;
        logic        pair_odd;
        logic [2:0]  nfields;
        logic        got_char;
        bit          emitted;
        out_beat_t   beat_out;
        out_beat_t   extracted_q[$];
        int unsigned errors;
        int unsigned live_beats;
        int unsigned n_checked;
        int unsigned n_text;
        int unsigned n_empty;
        int unsigned n_end;
        int unsigned n_bad;

        function new();
            restart();
        endfunction

        function void restart();
            phase      = PH_HEADER;
            step       = '0;
            tag_left   = '0;
            frame_left = '0;
            frame_id   = '0;
            field      = '0;
            enc_mode   = '0;
            pair_odd   = 1'b0;
            nfields    = '0;
            got_char   = 1'b0;
        endfunction

        function void emit(logic [2:0] st, logic [2:0] code, logic [7:0] ch, logic last,
                           logic done);
            emitted                = 1'b1;
            beat_out.status        = st;
            beat_out.field_code    = code;
            beat_out.text_char     = ch;
            beat_out.last_of_field = last;
            beat_out.tag_done      = done;
        endfunction

        function void halt(logic [2:0] st);
            emit(st, 3'd0, 8'd0, 1'b0, 1'b1);
            phase = PH_STOPPED;
        endfunction

        function void close_field(logic [2:0] st, logic [7:0] ch);
            logic stop;
            stop = (nfields >= FIELD_LIMIT);
            emit(st, field, ch, 1'b1, stop);
            if (stop) begin
                phase = PH_STOPPED;
            end
        endfunction

        function void frame_end();
            if (frame_left == 0) begin
                if (phase != PH_SKIP && !got_char && !emitted) begin
                    close_field(ST_EMPTY_FIELD, 8'd0);
                end
                if (phase != PH_STOPPED) begin
                    phase = PH_FRAME_HDR;
                    step  = '0;
                end
            end
        endfunction

        function void extract_byte(in_beat_t beat);
            logic [7:0]  b;
            logic [31:0] prior;
            int          hit;
            int          k;
            b = beat.data_byte;
            if (beat.start_of_file) begin
                restart();
            end
            emitted  = 1'b0;
            beat_out = '0;
            if (phase == PH_HEADER) begin
                case (step)
                    4'd0: if (b != MAGIC_0) halt(ST_BAD_MAGIC);
                    4'd1: if (b != MAGIC_1) halt(ST_BAD_MAGIC);
                    4'd2: if (b != MAGIC_2) halt(ST_BAD_MAGIC);
                    4'd3: if (b != MAJOR_VER) halt(ST_BAD_VERSION);
                    4'd4, 4'd5: ;
                    default: tag_left = {tag_left[20:0], b[6:0]};
                endcase
                if (phase == PH_HEADER) begin
                    if (step >= 4'd9) begin
                        step = '0;
                        if (tag_left == 0) begin
                            halt(ST_TAG_DONE);
                        end else begin
                            phase = PH_FRAME_HDR;
                        end
                    end else begin
                        step = step + 1'b1;
                    end
                end
            end else if (phase != PH_STOPPED) begin
                if (tag_left == 0) begin
                    halt(ST_TAG_DONE);
                end else begin
                    tag_left = tag_left - 1'b1;
                    case (phase)
                        PH_FRAME_HDR: begin
                            if (step == 0 && b == 8'd0) begin
                                halt(ST_TAG_DONE);
                            end else begin
                                if (step < 4'd4) begin
                                    frame_id = {frame_id[23:0], b};
                                end else if (step < 4'd8) begin
                                    frame_left = {frame_left[23:0], b};
                                end
                                if (step >= 4'd9) begin
                                    step = '0;
                                    if (frame_left > {4'd0, tag_left}) begin
                                        frame_left = {4'd0, tag_left};
                                    end
                                    if (frame_left != 0) begin
                                        phase = PH_ENCODING;
                                    end
                                end else begin
                                    step = step + 1'b1;
                                end
                            end
                        end
                        PH_ENCODING: begin
                            hit = -1;
                            for (k = 0; k < 6; k++) begin
                                if (hit < 0 && TEXT_FRAME_IDS[k] == frame_id) begin
                                    hit = k;
                                end
                            end
                            if (frame_left != 0) begin
                                frame_left = frame_left - 1'b1;
                            end
                            if (hit < 0 || b > ENC_UTF16_BE) begin
                                phase = PH_SKIP;
                            end else begin
                                field    = 3'(hit);
                                enc_mode = b[1:0];
                                pair_odd = 1'b0;
                                got_char = 1'b0;
                                step     = '0;
                                nfields  = nfields + 1'b1;
                                phase    = (b == ENC_UTF16) ? PH_BOM : PH_TEXT;
                            end
                            frame_end();
                        end
                        PH_BOM: begin
                            if (frame_left != 0) begin
                                frame_left = frame_left - 1'b1;
                            end
                            step = step + 1'b1;
                            if (step >= 4'd2) begin
                                step  = '0;
                                phase = PH_TEXT;
                            end
                            frame_end();
                        end
                        PH_TEXT: begin
                            prior = frame_left;
                            if (frame_left != 0) begin
                                frame_left = frame_left - 1'b1;
                            end
                            if (enc_mode == 2'(ENC_LATIN)) begin
                                got_char = 1'b1;
                                if (frame_left == 0) begin
                                    close_field(ST_TEXT_CHAR, b);
                                end else begin
                                    emit(ST_TEXT_CHAR, field, b, 1'b0, 1'b0);
                                end
                            end else if (!pair_odd) begin
                                if (prior >= 2) begin
                                    got_char = 1'b1;
                                    pair_odd = 1'b1;
                                    if (frame_left < 3) begin
                                        close_field(ST_TEXT_CHAR, b);
                                    end else begin
                                        emit(ST_TEXT_CHAR, field, b, 1'b0, 1'b0);
                                    end
                                end
                            end else begin
                                pair_odd = 1'b0;
                            end
                            frame_end();
                        end
                        default: begin
                            if (frame_left != 0) begin
                                frame_left = frame_left - 1'b1;
                            end
                            frame_end();
                        end
                    endcase
                    if (phase != PH_STOPPED && tag_left == 0) begin
                        if (emitted) begin
                            beat_out.tag_done = 1'b1;
                        end else begin
                            emit(ST_TAG_DONE, 3'd0, 8'd0, 1'b0, 1'b1);
                        end
                        phase = PH_STOPPED;
                    end
                end
            end
        endfunction

        function void note_byte(in_beat_t beat);
            if (beat.start_of_file || phase != PH_STOPPED) begin
                live_beats++;
            end
            extract_byte(beat);
            if (emitted) begin
                extracted_q.push_back(beat_out);
                case (beat_out.status)
                    ST_TEXT_CHAR:   n_text++;
                    ST_EMPTY_FIELD: n_empty++;
                    ST_TAG_DONE:    n_end++;
                    default:        n_bad++;
                endcase
            end
        endfunction

        function int unsigned pending();
            return extracted_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("ERROR: result %0d: %s", n_checked, msg);
            end
        endtask

        task check_result(out_beat_t got);
            out_beat_t want;
            n_checked++;
            if (extracted_q.size() == 0) begin
                report($sformatf("unexpected beat %h", got));
                return;
            end
            want = extracted_q.pop_front();
            if (got.status != want.status) begin
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            end
            if (got.field_code != want.field_code) begin
                report($sformatf("field_code %0d, expected %0d", got.field_code,
                                 want.field_code));
            end
            if (got.text_char != want.text_char) begin
                report($sformatf("text_char %02h, expected %02h", got.text_char,
                                 want.text_char));
            end
            if (got.last_of_field != want.last_of_field) begin
                report($sformatf("last_of_field %0d, expected %0d", got.last_of_field,
                                 want.last_of_field));
            end
            if (got.tag_done != want.tag_done) begin
                report($sformatf("tag_done %0d, expected %0d", got.tag_done, want.tag_done));
            end
        endtask
    endclass

endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ID3 text frame extractor testbench
// Streams short hand-built tags that hit each header error and frame corner,
// then random tags, truncated tags and noise through the extractor while both
// sides stall at random, and checks every result beat against a prediction.
// ----------------------------------------------------------------------------
module testbench;
    import id3tfe_pkg::*;
    import id3tfe_tb_pkg::*;

    localparam int unsigned HOLD_CYCLES = 400;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_token  = 0;
    int unsigned seen_token  = 0;
    int unsigned hold_left   = 0;
    logic [7:0]  file_q[$];

    id3_text_scoreboard sb = new();

    id3_text_frame_extractor_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_byte(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_token != seen_token) begin
            seen_token <= hold_token;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void put_header(bit noisy);
        file_q.delete();
        file_q.push_back(MAGIC_0);
        file_q.push_back(MAGIC_1);
        file_q.push_back(MAGIC_2);
        file_q.push_back(MAJOR_VER);
        file_q.push_back(noisy ? 8'($urandom) : 8'h00);
        file_q.push_back(noisy ? 8'($urandom) : 8'h00);
        repeat (4) file_q.push_back(8'h00);
    endfunction

    function automatic void seal_tag(logic [27:0] size, logic top);
        file_q[6] = {top, size[27:21]};
        file_q[7] = {top, size[20:14]};
        file_q[8] = {top, size[13:7]};
        file_q[9] = {top, size[6:0]};
    endfunction

    function automatic void put_frame_hdr(logic [31:0] id, logic [31:0] size);
        int k;
        for (k = 3; k >= 0; k--) begin
            file_q.push_back(id[8*k +: 8]);
        end
        for (k = 3; k >= 0; k--) begin
            file_q.push_back(size[8*k +: 8]);
        end
        repeat (2) file_q.push_back(8'($urandom));
    endfunction

    function automatic void push_text(int unsigned n);
        repeat (n) file_q.push_back(8'($urandom));
    endfunction

    task automatic send_beat(logic [7:0] b, logic sof);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= '{data_byte: b, start_of_file: sof};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_file(int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            send_beat(file_q[i], i == 0);
        end
    endtask

    task automatic wait_drained();
        int unsigned guard;
        guard = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    initial begin
        int unsigned kind;
        int unsigned nfr;
        int unsigned n;
        int unsigned body;
        int unsigned len;
        int unsigned tag_span;
        int unsigned base;
        int unsigned r;
        int unsigned i;
        int          ph;
        logic [31:0] id;
        logic [31:0] fsize;
        logic [7:0]  enc;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_idle_pct = 26;
        rx_idle_pct <= 45;

        put_header(1'b0);
        file_q[0] = 8'hFF;
        send_file(1);
        put_header(1'b0);
        file_q[1] = 8'h00;
        send_file(2);
        put_header(1'b0);
        file_q[2] = 8'hFF;
        send_file(3);
        put_header(1'b0);
        file_q[3] = 8'h04;
        send_file(4);

        put_header(1'b0);
        send_file(10);
        send_beat(8'hAA, 1'b0);

        put_header(1'b0);
        put_frame_hdr("TPE1", 2);
        file_q.push_back(ENC_LATIN);
        file_q.push_back("A");
        put_frame_hdr("TIT2", 6);
        file_q.push_back(ENC_UTF16);
        file_q.push_back(8'hFF);
        file_q.push_back(8'hFE);
        file_q.push_back("x");
        file_q.push_back(8'h00);
        file_q.push_back("y");
        put_frame_hdr("TXXX", 3);
        file_q.push_back(ENC_LATIN);
        push_text(2);
        put_frame_hdr("TALB", 0);
        put_frame_hdr("TYER", 1);
        file_q.push_back(ENC_LATIN);
        put_frame_hdr("TCON", 2);
        file_q.push_back(8'hFF);
        file_q.push_back("z");
        put_frame_hdr("TCON", 3);
        file_q.push_back(ENC_UTF16_BE);
        file_q.push_back("5");
        file_q.push_back(8'h00);
        repeat (3) file_q.push_back(8'h00);
        seal_tag(28'(file_q.size() - 10), 1'b0);
        send_file(file_q.size());

        put_header(1'b0);
        for (i = 0; i < 6; i++) begin
            put_frame_hdr(TEXT_FRAME_IDS[i], 2);
            file_q.push_back(ENC_LATIN);
            push_text(1);
        end
        put_frame_hdr("TCOM", 2);
        file_q.push_back(ENC_LATIN);
        push_text(1);
        seal_tag(28'(file_q.size() - 10), 1'b0);
        send_file(file_q.size());

        put_header(1'b0);
        put_frame_hdr("TIT2", 5);
        file_q.push_back(ENC_LATIN);
        push_text(4);
        seal_tag(28'd13, 1'b0);
        send_file(file_q.size());

        put_header(1'b0);
        put_frame_hdr("COMM", 32'hFFFF_FFFF);
        file_q.push_back(ENC_LATIN);
        push_text(3);
        seal_tag(28'd12, 1'b0);
        send_file(file_q.size());

        put_header(1'b0);
        seal_tag(28'hFFF_FFFF, 1'b1);
        put_frame_hdr("TALB", 3);
        file_q.push_back(ENC_UTF16_BE);
        file_q.push_back("k");
        file_q.push_back(8'h00);
        put_frame_hdr("TPE1", 9);
        file_q.push_back(ENC_LATIN);
        send_file(file_q.size());

        base = sb.live_beats;
        for (ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                tx_idle_pct = 45;
                rx_idle_pct <= 26;
            end else if (ph == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                hold_token <= hold_token + 1;
            end
            while (sb.live_beats < base + (ph + 1) * 75) begin
                kind = $urandom_range(99);
                if (kind < 12) begin
                    n = $urandom_range(12, 1);
                    for (i = 0; i < n; i++) begin
                        send_beat(8'($urandom),
                                  (i == 0) ? 1'($urandom) : ($urandom_range(15) == 0));
                    end
                end else begin
                    put_header(1'b1);
                    if (kind < 20) begin
                        file_q[$urandom_range(3)] = 8'($urandom);
                    end
                    nfr = $urandom_range(7, 1);
                    repeat (nfr) begin
                        if ($urandom_range(99) < 80) begin
                            id = TEXT_FRAME_IDS[$urandom_range(5)];
                        end else begin
                            id = $urandom;
                            if (id[31:24] == 8'h00 && $urandom_range(3) != 0) begin
                                id[31:24] = "T";
                            end
                        end
                        enc  = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 3))
                                                        : 8'($urandom_range(2));
                        n    = $urandom_range(6);
                        body = 1 + ((enc == ENC_UTF16) ? 2 : 0) + n;
                        r    = $urandom_range(19);
                        fsize = (r == 0) ? 32'd0 : (r == 1) ? 32'($urandom) : 32'(body);
                        put_frame_hdr(id, fsize);
                        if (fsize != 0) begin
                            file_q.push_back(enc);
                            if (enc == ENC_UTF16) begin
                                push_text(2);
                            end
                            push_text(n);
                        end
                    end
                    repeat ($urandom_range(3)) file_q.push_back(8'h00);
                    tag_span = file_q.size() - 10;
                    if ($urandom_range(4) == 0) begin
                        tag_span = $urandom_range(tag_span, 1);
                    end
                    seal_tag(28'(tag_span), ($urandom_range(3) == 0));
                    repeat ($urandom_range(2)) file_q.push_back(8'($urandom));
                    len = file_q.size();
                    if ($urandom_range(9) == 0) begin
                        len = $urandom_range(len, 1);
                    end
                    send_file(len);
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("Parsed %0d live bytes of tag headers, text and other frames, and noise.",
                 sb.live_beats);
        $display("Checked %0d results: %0d chars, %0d empty fields, %0d tag ends, %0d bad headers.",
                 sb.n_checked, sb.n_text, sb.n_empty, sb.n_end, sb.n_bad);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Run did not complete within 2 ms of simulated time.");
        $display("Verification failed");
        $finish;
    end

endmodule
